/* src/lcs_pkg.sv */
package lcs_pkg;

    // World limits and field widths
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int SIZE_W      = 11;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int OUT_COORD_W = 10;
    localparam int MIN_SIZE    = 3;

    // Line buffer entry: bit 0 is two rows up, bit 1 is one row up
    localparam int LINE_DATA_W = 2;

    // Result queue
    localparam int OUT_DEPTH = 3;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Register map, indexed by paddr[2]
    localparam logic REG_GRID_HEIGHT = 1'b0;
    localparam logic REG_GRID_WIDTH  = 1'b1;

    localparam logic [SIZE_W-1:0] GRID_HEIGHT_RESET = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] GRID_WIDTH_RESET  = SIZE_W'(64);

    // One result as it waits in the queue
    typedef struct packed {
        logic                   next_alive;
        logic [OUT_COORD_W-1:0] out_row;
        logic [OUT_COORD_W-1:0] out_col;
        logic                   frame_last;
    } out_item_t;

endpackage

/* src/lcs_line_ram.sv */
module lcs_line_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 2
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, write-first on a same-address collision
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/lcs_out_fifo.sv */
module lcs_out_fifo (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  lcs_pkg::out_item_t        push_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output lcs_pkg::out_item_t        out_item,
    output logic [lcs_pkg::OUT_CNT_W-1:0] count
);
    import lcs_pkg::*;

    out_item_t              slot_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0]   count_reg, count_next;
    logic                   pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold results until taken
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/life_cell_stencil_step.sv */
// Chan  Dir     Signals                                                      Request
// s_    in      s_valid s_ready s_cell_alive s_frame_start                    one current cell
// m_    out     m_valid m_ready m_next_alive m_out_row m_out_col m_frame_last one result cell
// apb   in/out  psel penable pwrite paddr pwdata prdata pready                register access
//
// One cell is taken per clock while s_ready is high, a rate set by the line buffer RAM's one
// read and one write port. Steps of a cell: RAM read and stage register load at its accepting
// edge, then window update, write-back and queue push, after which the queue offers the result.
// Reset clears counters, window, queue and registers; a pass over all MAX_WIDTH entries then
// zeroes the line buffer RAM with s_ready low. A three-entry queue absorbs m_ready stalls;
// s_ready drops while the queue and the cell in flight hold three results.
module life_cell_stencil_step (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cell_alive,
    input  logic        s_frame_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_next_alive,
    output logic [9:0]  m_out_row,
    output logic [9:0]  m_out_col,
    output logic        m_frame_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lcs_pkg::*;

    typedef struct packed {
        logic                   alive;
        logic [COL_W-1:0]       addr;
        logic                   produce;
        logic                   border;
        logic                   last;
        logic [OUT_COORD_W-1:0] orow;
        logic [OUT_COORD_W-1:0] ocol;
    } stage_t;

    logic [SIZE_W-1:0]    grid_height_reg, grid_width_reg;
    logic [SIZE_W-1:0]    height, width;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [SIZE_W-1:0]    c_base, r_base, c_cur, r_adv, r_cur, c_inc, r_inc;
    logic                 accept;
    stage_t               s1_reg, s1_next;
    logic                 s1_valid_reg;
    logic [8:0]           window_reg, window_next;
    logic [LINE_DATA_W-1:0] rd_data, wr_data;
    logic                 clr_busy_reg;
    logic [COL_W-1:0]     clr_addr_reg;
    logic                 ram_wr_en;
    logic [COL_W-1:0]     ram_wr_addr;
    logic [3:0]           neigh_cnt;
    logic                 centre, rule_alive;
    out_item_t            push_item;
    logic                 push;
    logic [OUT_CNT_W-1:0] q_count;
    logic [OUT_CNT_W:0]   q_load;
    out_item_t            head;
    logic                 cfg_write;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_height_reg <= GRID_HEIGHT_RESET;
            grid_width_reg  <= GRID_WIDTH_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[SIZE_W-1:0];
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[SIZE_W-1:0];
                default:         grid_height_reg <= grid_height_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_GRID_HEIGHT: prdata = {{(32 - SIZE_W){1'b0}}, grid_height_reg};
            REG_GRID_WIDTH:  prdata = {{(32 - SIZE_W){1'b0}}, grid_width_reg};
            default:         prdata = '0;
        endcase
    end

    // Clamp sizes to the supported range
    always_comb begin
        if (grid_height_reg < SIZE_W'(MIN_SIZE)) begin
            height = SIZE_W'(MIN_SIZE);
        end else if (grid_height_reg > SIZE_W'(MAX_HEIGHT)) begin
            height = SIZE_W'(MAX_HEIGHT);
        end else begin
            height = grid_height_reg;
        end
        if (grid_width_reg < SIZE_W'(MIN_SIZE)) begin
            width = SIZE_W'(MIN_SIZE);
        end else if (grid_width_reg > SIZE_W'(MAX_WIDTH)) begin
            width = SIZE_W'(MAX_WIDTH);
        end else begin
            width = grid_width_reg;
        end
    end

    // Input side: hold off during the clearing pass, then accept while the queue plus the
    // item in flight leave room
    assign q_load  = {1'b0, q_count} + {{OUT_CNT_W{1'b0}}, (s1_valid_reg && s1_reg.produce)};
    assign s_ready = !clr_busy_reg && (q_load < (OUT_CNT_W + 1)'(OUT_DEPTH));
    assign accept  = s_valid && s_ready;

    // Position of the incoming cell, wrapped against the current sizes
    always_comb begin
        c_base = s_frame_start ? '0 : {{(SIZE_W - COL_W){1'b0}}, col_reg};
        r_base = s_frame_start ? '0 : {{(SIZE_W - ROW_W){1'b0}}, row_reg};
        if (c_base >= width) begin
            c_cur = '0;
            r_adv = r_base + 1'b1;
        end else begin
            c_cur = c_base;
            r_adv = r_base;
        end
        r_cur = (r_adv >= height) ? '0 : r_adv;
        c_inc = c_cur + 1'b1;
        r_inc = r_cur + 1'b1;
        if (c_inc >= width) begin
            col_next = '0;
            row_next = (r_inc >= height) ? '0 : r_inc[ROW_W-1:0];
        end else begin
            col_next = c_inc[COL_W-1:0];
            row_next = r_cur[ROW_W-1:0];
        end
    end

    // Describe the output cell for the next stage
    always_comb begin
        s1_next.alive   = s_cell_alive;
        s1_next.addr    = c_cur[COL_W-1:0];
        s1_next.produce = (r_cur != '0) && (c_cur != '0);
        s1_next.orow    = OUT_COORD_W'(r_cur - 1'b1);
        s1_next.ocol    = OUT_COORD_W'(c_cur - 1'b1);
        s1_next.border  = (r_cur == SIZE_W'(1)) || (c_cur == SIZE_W'(1));
        s1_next.last    = (r_cur == height - 1'b1) && (c_cur == width - 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= s1_next;
        end
    end

    // Zero the line buffer RAM after reset, one entry per clock
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == COL_W'(MAX_WIDTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Line buffers: both rows above share one RAM entry per column
    assign wr_data     = clr_busy_reg ? '0 : {s1_reg.alive, rd_data[1]};
    assign ram_wr_en   = clr_busy_reg || s1_valid_reg;
    assign ram_wr_addr = clr_busy_reg ? clr_addr_reg : s1_reg.addr;

    lcs_line_ram #(
        .ADDR_W (COL_W),
        .DATA_W (LINE_DATA_W)
    ) u_line_ram (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (c_cur[COL_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (wr_data)
    );

    // Slide the window by one column
    assign window_next = {s1_reg.alive, rd_data, window_reg[8:3]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else if (s1_valid_reg) begin
            window_reg <= window_next;
        end
    end

    // Count neighbours and apply birth on three, survival on two or three
    always_comb begin
        neigh_cnt = '0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                neigh_cnt = neigh_cnt + {3'b000, window_next[k]};
            end
        end
        centre     = window_next[4];
        rule_alive = (neigh_cnt == 4'd3) || (centre && (neigh_cnt == 4'd2));
    end

    assign push                 = s1_valid_reg && s1_reg.produce;
    assign push_item.next_alive = !s1_reg.border && rule_alive;
    assign push_item.out_row    = s1_reg.orow;
    assign push_item.out_col    = s1_reg.ocol;
    assign push_item.frame_last = s1_reg.last;

    lcs_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (head),
        .count     (q_count)
    );

    assign m_next_alive = head.next_alive;
    assign m_out_row    = head.out_row;
    assign m_out_col    = head.out_col;
    assign m_frame_last = head.frame_last;

endmodule

/* src/lcs_checker.sv */
module lcs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_next_alive,
    input logic [9:0] m_out_row,
    input logic [9:0] m_out_col,
    input logic       m_frame_last
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_next_alive) && $stable(m_out_row)
            && $stable(m_out_col) && $stable(m_frame_last))
        else $error("stalled result changed");

    // Border cells in row 0 or column 0 are always dead
    a_border_dead: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_row == 10'd0 || m_out_col == 10'd0) |-> !m_next_alive)
        else $error("border cell reported alive");

    // The last cell of a generation lies inside the border
    a_last_inner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_last |-> m_out_row != 10'd0 && m_out_col != 10'd0)
        else $error("frame end on a border cell");

    // A result appears only after a cell was taken and passed the stage register into the queue
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a matching input");

endmodule

bind life_cell_stencil_step lcs_checker u_lcs_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_next_alive (m_next_alive),
    .m_out_row    (m_out_row),
    .m_out_col    (m_out_col),
    .m_frame_last (m_frame_last)
);
